### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### src/lrip_pkg.sv
package lrip_pkg;

	localparam int DEF_ROWS    = 16;
	localparam int DEF_COLUMNS = 1800;

	localparam int CORDIC_STEPS = 23;
	localparam int SQRT_STEPS   = 24;
	localparam int ANG_W        = 26;

	// atan(2^-i) in 1/65536 degree
	localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
		26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833, 26'sd917,
		26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2,
		26'sd1
	};

	localparam logic signed [ANG_W-1:0] ANG_90  = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] ANG_180 = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] ANG_360 = 26'sd23592960;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ROW   = 2'd1;
	localparam logic [1:0] ST_COL   = 2'd2;
	localparam logic [1:0] ST_CLOSE = 2'd3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_USE_RING  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_RES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_RES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 3'd4;

	typedef struct packed {
		logic        use_ring;
		logic [22:0] bottom_angle;
		logic [19:0] row_resolution;
		logic [19:0] column_resolution;
		logic [20:0] minimum_range;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		use_ring:          1'b0,
		bottom_angle:      23'd989594,
		row_resolution:    20'd131072,
		column_resolution: 20'd13107,
		minimum_range:     21'd1024
	};

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic [7:0]         ring_number;
	} point_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  image_row;
		logic [10:0] image_column;
		logic [14:0] cell_index;
		logic [23:0] point_range;
	} result_t;

endpackage

### src/lrip_pipe.sv
module lrip_pipe #(
	parameter int ROWS    = lrip_pkg::DEF_ROWS,
	parameter int COLUMNS = lrip_pkg::DEF_COLUMNS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  lrip_pkg::point_t  in_item,
	input  lrip_pkg::cfg_t    cfg,
	output logic              out_valid,
	output lrip_pkg::result_t out_item
);
	import lrip_pkg::*;

	localparam int VW    = 43;
	localparam int QLIM  = 2 * COLUMNS;
	localparam int QW    = $clog2(QLIM + 1);
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CDIV  = (QW + 1) / 2;
	localparam int RDIV  = (RW + 1) / 2;
	localparam int SQ_ST = SQRT_STEPS / 2;
	localparam int C_ST  = (CORDIC_STEPS + 1) / 2;
	localparam int LIM_W = 21 + QW;
	localparam int RLW   = 20 + RW;
	localparam int CCW   = (27 > LIM_W) ? 27 : LIM_W;
	localparam int RCW   = (26 > RLW) ? 26 : RLW;

	localparam int P_SUM   = 1;
	localparam int P_AZ0   = 2;
	localparam int P_EPREP = P_AZ0 + ((SQ_ST > C_ST) ? SQ_ST : C_ST);
	localparam int P_EL0   = P_EPREP + 1;
	localparam int P_RPREP = P_EL0 + ((C_ST > CDIV + 1) ? C_ST : CDIV + 1);
	localparam int P_RCMP  = P_RPREP + 1;
	localparam int P_RDIV0 = P_RCMP + 1;
	localparam int P_FIN   = P_RDIV0 + RDIV;
	localparam int NST     = P_FIN + 1;

	localparam logic signed [15:0] COLS_S = 16'(COLUMNS);
	localparam logic signed [15:0] HALF_S = 16'(COLUMNS / 2);

	typedef struct packed {
		logic [47:0] n;
		logic [25:0] rem;
		logic [23:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [VW-1:0]    vx;
		logic signed [VW-1:0]    vy;
		logic signed [ANG_W-1:0] ang;
		logic                    sp;
	} cordic_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [7:0]         ring;
		logic [46:0]        sx;
		logic [46:0]        sy;
		logic [46:0]        sz;
		sqrt_t              hs;
		sqrt_t              rs;
		cordic_t            cd;
		logic               c_neg;
		logic [26:0]        c_rem;
		logic [QW-1:0]      c_q;
		logic               r_neg;
		logic               r_bad;
		logic [25:0]        r_rem;
		logic [RW-1:0]      r_q;
		result_t            res;
	} work_t;

	function automatic sqrt_t sqrt_step(sqrt_t s);
		sqrt_t       r;
		logic [27:0] cur;
		logic [27:0] trial;
		r = s;
		cur = {s.rem, s.n[47:46]};
		trial = {2'b00, s.root, 2'b01};
		r.n = {s.n[45:0], 2'b00};
		if (cur >= trial) begin
			r.rem = 26'(cur - trial);
			r.root = {s.root[22:0], 1'b1};
		end else begin
			r.rem = cur[25:0];
			r.root = {s.root[22:0], 1'b0};
		end
		return r;
	endfunction

	// angle of vector (b, a), axis cases resolved up front
	function automatic cordic_t cordic_init(logic signed [24:0] a, logic signed [24:0] b);
		cordic_t r;
		r.sp = 1'b0;
		r.ang = '0;
		r.vx = VW'(b) <<< 16;
		r.vy = VW'(a) <<< 16;
		if (a == 0) begin
			r.sp = 1'b1;
			r.ang = (b < 0) ? ANG_180 : '0;
		end else if (b == 0) begin
			r.sp = 1'b1;
			r.ang = (a > 0) ? ANG_90 : -ANG_90;
		end else if (b < 0) begin
			r.ang = (a > 0) ? ANG_180 : -ANG_180;
			r.vx = -r.vx;
			r.vy = -r.vy;
		end
		return r;
	endfunction

	function automatic cordic_t cordic_step(cordic_t c, int i);
		cordic_t              r;
		logic signed [VW-1:0] dx;
		logic signed [VW-1:0] dy;
		r = c;
		dx = c.vy >>> i;
		dy = c.vx >>> i;
		if (c.vy > 0) begin
			r.vx = c.vx + dx;
			r.vy = c.vy - dy;
			if (!c.sp) r.ang = c.ang + ATAN_TAB[i];
		end else begin
			r.vx = c.vx - dx;
			r.vy = c.vy + dy;
			if (!c.sp) r.ang = c.ang - ATAN_TAB[i];
		end
		return r;
	endfunction

	function automatic logic signed [ANG_W-1:0] norm_angle(logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] r;
		r = a;
		if (a > ANG_180) r = a - ANG_360;
		else if (a <= -ANG_180) r = a + ANG_360;
		return r;
	endfunction

	logic [19:0]      rres_e;
	logic [19:0]      cres_e;
	logic [20:0]      c_den;
	logic [LIM_W-1:0] col_lim_q;
	logic [RLW-1:0]   row_lim_q;

	assign rres_e = (cfg.row_resolution == '0) ? 20'd1 : cfg.row_resolution;
	assign cres_e = (cfg.column_resolution == '0) ? 20'd1 : cfg.column_resolution;
	assign c_den  = {cres_e, 1'b0};

	// limits follow the registers; the user must change them only while the pipe is empty, the block does not enforce it
	always_ff @(posedge clk) begin
		col_lim_q <= LIM_W'(c_den) * LIM_W'(QLIM);
		row_lim_q <= RLW'(rres_e) * RLW'(ROWS);
	end

	work_t          work_s [NST];
	logic [NST-1:0] valid_s;

	for (genvar k = 0; k < NST; k++) begin : g_st
		work_t prev;
		work_t nxt;
		logic  prev_v;

		if (k == 0) begin : g_in
			always_comb begin
				prev = '0;
				prev.x = in_item.point_x;
				prev.y = in_item.point_y;
				prev.z = in_item.point_z;
				prev.ring = in_item.ring_number;
			end
			assign prev_v = in_valid;
		end else begin : g_mid
			assign prev = work_s[k-1];
			assign prev_v = valid_s[k-1];
		end

		always_comb begin
			logic [23:0]             ax;
			logic [23:0]             ay;
			logic [23:0]             az;
			logic signed [ANG_W-1:0] ang;
			logic signed [26:0]      dv;
			logic [25:0]             ad;
			logic [7:0]              row;
			logic                    row_bad;
			logic signed [15:0]      qs;
			logic signed [15:0]      col;
			logic                    col_bad;
			logic [19:0]             cidx;
			int                      b;
			ax = '0;
			ay = '0;
			az = '0;
			ang = '0;
			dv = '0;
			ad = '0;
			row = '0;
			row_bad = 1'b0;
			qs = '0;
			col = '0;
			col_bad = 1'b0;
			cidx = '0;
			b = 0;
			nxt = prev;

			if (k == 0) begin
				ax = prev.x[23] ? 24'(-prev.x) : 24'(prev.x);
				ay = prev.y[23] ? 24'(-prev.y) : 24'(prev.y);
				az = prev.z[23] ? 24'(-prev.z) : 24'(prev.z);
				nxt.sx = 47'(48'(ax) * 48'(ax));
				nxt.sy = 47'(48'(ay) * 48'(ay));
				nxt.sz = 47'(48'(az) * 48'(az));
			end

			if (k == P_SUM) begin
				nxt.hs.n = 48'(prev.sx) + 48'(prev.sy);
				nxt.rs.n = nxt.hs.n + 48'(prev.sz);
				nxt.hs.rem = '0;
				nxt.hs.root = '0;
				nxt.rs.rem = '0;
				nxt.rs.root = '0;
				nxt.cd = cordic_init(25'(prev.x), 25'(prev.y));
			end

			if (k >= P_AZ0 && k < P_AZ0 + SQ_ST) begin
				for (int j = 0; j < 2; j++) begin
					nxt.hs = sqrt_step(nxt.hs);
					nxt.rs = sqrt_step(nxt.rs);
				end
			end

			// azimuth, then elevation on the same rotator fields
			if (k >= P_AZ0 && k < P_AZ0 + C_ST) begin
				for (int j = 0; j < 2; j++) begin
					if (2 * (k - P_AZ0) + j < CORDIC_STEPS)
						nxt.cd = cordic_step(nxt.cd, 2 * (k - P_AZ0) + j);
				end
			end

			if (k == P_EPREP) begin
				ang = norm_angle(prev.cd.ang);
				dv = 27'(ang) - 27'(ANG_90);
				nxt.c_neg = dv[26];
				ad = dv[26] ? 26'(-dv) : 26'(dv);
				nxt.c_rem = {ad, 1'b0} + 27'(cres_e);
				nxt.cd = cordic_init(25'(prev.z), {1'b0, prev.hs.root});
			end

			if (k >= P_EL0 && k < P_EL0 + C_ST) begin
				for (int j = 0; j < 2; j++) begin
					if (2 * (k - P_EL0) + j < CORDIC_STEPS)
						nxt.cd = cordic_step(nxt.cd, 2 * (k - P_EL0) + j);
				end
			end

			// quotient too large for any column: clamp, skip the divide
			if (k == P_EL0) begin
				if (CCW'(prev.c_rem) >= CCW'(col_lim_q)) begin
					nxt.c_q = QW'(QLIM);
					nxt.c_rem = '0;
				end else begin
					nxt.c_q = '0;
				end
			end

			if (k > P_EL0 && k <= P_EL0 + CDIV) begin
				for (int j = 0; j < 2; j++) begin
					b = QW - 1 - 2 * (k - P_EL0 - 1) - j;
					if (b >= 0) begin
						if (CCW'(nxt.c_rem) >= (CCW'(c_den) << b)) begin
							nxt.c_rem = 27'(CCW'(nxt.c_rem) - (CCW'(c_den) << b));
							nxt.c_q[b] = 1'b1;
						end
					end
				end
			end

			if (k == P_RPREP) begin
				ang = norm_angle(prev.cd.ang);
				dv = 27'(ang) + $signed({4'b0000, cfg.bottom_angle});
				nxt.r_neg = dv[26];
				nxt.r_rem = dv[26] ? 26'(-dv) : 26'(dv);
			end

			// negative sums above minus one row truncate to row zero
			if (k == P_RCMP) begin
				nxt.r_q = '0;
				if (prev.r_neg) begin
					nxt.r_bad = RCW'(prev.r_rem) >= RCW'(rres_e);
					nxt.r_rem = '0;
				end else begin
					nxt.r_bad = RCW'(prev.r_rem) >= RCW'(row_lim_q);
					if (nxt.r_bad) nxt.r_rem = '0;
				end
			end

			if (k >= P_RDIV0 && k < P_RDIV0 + RDIV) begin
				for (int j = 0; j < 2; j++) begin
					b = RW - 1 - 2 * (k - P_RDIV0) - j;
					if (b >= 0) begin
						if (RCW'(nxt.r_rem) >= (RCW'(rres_e) << b)) begin
							nxt.r_rem = 26'(RCW'(nxt.r_rem) - (RCW'(rres_e) << b));
							nxt.r_q[b] = 1'b1;
						end
					end
				end
			end

			if (k == P_FIN) begin
				if (cfg.use_ring) begin
					row = prev.ring;
					row_bad = int'(prev.ring) >= ROWS;
				end else begin
					row = 8'(prev.r_q);
					row_bad = prev.r_bad;
				end
				qs = $signed(16'(prev.c_q));
				col = prev.c_neg ? HALF_S + qs : HALF_S - qs;
				if (col >= COLS_S) col = col - COLS_S;
				col_bad = (col < 0) || (col >= COLS_S);
				cidx = 20'(row) * 20'(COLUMNS) + 20'(col);
				nxt.res.point_range = prev.rs.root;
				if (row_bad) nxt.res.status = ST_ROW;
				else if (col_bad) nxt.res.status = ST_COL;
				else if (prev.rs.root < {3'b000, cfg.minimum_range}) nxt.res.status = ST_CLOSE;
				else nxt.res.status = ST_OK;
				if (nxt.res.status == ST_OK) begin
					nxt.res.image_row = row[3:0];
					nxt.res.image_column = col[10:0];
					nxt.res.cell_index = cidx[14:0];
				end else begin
					nxt.res.image_row = '0;
					nxt.res.image_column = '0;
					nxt.res.cell_index = '0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_s[k] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[NST-1];
	assign out_item  = work_s[NST-1].res;

endmodule

### src/lidar_range_image_projection.sv
// lidar point to range image cell projection
// point channel: point_valid / point_ready carry one lidar point per item
//   (x, y, z in 1/1024 m, ring number); result channel: result_valid /
//   result_ready carry status, row, column, cell index and range.
// cfg channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always ready.
//   writes are registered; the user must write only while idle (not enforced).
// one result per point, in order; one item per cycle while point_ready is high.
// the pipe depth is set by the two square roots and the two 23-step rotator
//   passes, run two steps per stage, plus the row and column divides, each
//   resolving two quotient bits per stage.
// the pipeline moves as a whole; an output register plus one skid entry
//   keep it flowing while the receiver stalls, and point_ready drops only
//   once the skid entry is also full.
// reset clears all valid bits and loads the default register values.
`include "assert_macros.svh"

module lidar_range_image_projection #(
	parameter int ROWS    = lrip_pkg::DEF_ROWS,
	parameter int COLUMNS = lrip_pkg::DEF_COLUMNS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               point_valid,
	output logic                               point_ready,
	input  lrip_pkg::point_t                   point,
	output logic                               result_valid,
	input  logic                               result_ready,
	output lrip_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lrip_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lrip_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lrip_pkg::*;

	cfg_t    cfg_q;
	logic    en;
	logic    pipe_v;
	result_t pipe_item;
	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    take;
	logic    arrive;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_USE_RING:  cfg_q.use_ring <= cfg_data[0];
				CFG_BOTTOM:    cfg_q.bottom_angle <= cfg_data[22:0];
				CFG_ROW_RES:   cfg_q.row_resolution <= cfg_data[19:0];
				CFG_COL_RES:   cfg_q.column_resolution <= cfg_data[19:0];
				CFG_MIN_RANGE: cfg_q.minimum_range <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	assign en          = !skid_v_q;
	assign point_ready = en;

	lrip_pipe #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (point_valid),
		.in_item   (point),
		.cfg       (cfg_q),
		.out_valid (pipe_v),
		.out_item  (pipe_item)
	);

	assign take   = out_v_q && result_ready;
	assign arrive = pipe_v && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= arrive;
			end
		end else if (arrive) begin
			if (out_v_q) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_v_q) out_q <= skid_q;
			else if (arrive) out_q <= pipe_item;
		end else if (arrive) begin
			if (out_v_q) skid_q <= pipe_item;
			else out_q <= pipe_item;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	`ASSERT_NEVER(a_skid_without_out, skid_v_q && !out_v_q, "skid item behind an empty output register")
	`ASSERT_CLK(a_skid_held, skid_v_q && !result_ready |=> skid_v_q, "skid item lost during stall")
	`ASSERT_CLK(a_reject_clear, out_v_q && out_q.status != ST_OK |-> out_q.cell_index == '0 && out_q.image_column == '0 && out_q.image_row == '0, "rejected item carries a position")
	`ASSERT_CLK(a_cell_bound, out_v_q && out_q.status == ST_OK |-> (COLUMNS > 2048 || ROWS > 16) || (int'(out_q.image_column) < COLUMNS && int'(out_q.image_row) < ROWS), "accepted item outside the image")

endmodule

### tb/lidar_range_image_projection_tb.sv
`timescale 1ns / 100ps

module lidar_range_image_projection_tb;
	import lrip_pkg::*;

	localparam int ROWS    = DEF_ROWS;
	localparam int COLUMNS = DEF_COLUMNS;
	localparam int LATENCY = 40;

	typedef logic signed [63:0] s64_t;

	// cell projection predictor and queue of expected cell results
	class cell_board;
		cfg_t    regs;
		result_t pending_cells[$];
		int      failures;

		function new();
			regs = CFG_RESET;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_USE_RING:  regs.use_ring = data[0];
				CFG_BOTTOM:    regs.bottom_angle = data[22:0];
				CFG_ROW_RES:   regs.row_resolution = data[19:0];
				CFG_COL_RES:   regs.column_resolution = data[19:0];
				CFG_MIN_RANGE: regs.minimum_range = data[20:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] root_floor(logic [63:0] n);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function s64_t vector_angle(s64_t a, s64_t b);
			s64_t vx, vy, ang, dx, dy;
			s64_t deg180;
			deg180 = 180 * 65536;
			ang = 0;
			if (a == 0) return (b < 0) ? deg180 : 0;
			if (b == 0) return (a > 0) ? 90 * 65536 : -90 * 65536;
			vx = b * 65536;
			vy = a * 65536;
			if (vx < 0) begin
				ang = (a > 0) ? deg180 : -deg180;
				vx = -vx;
				vy = -vy;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy > 0) begin
					vx = vx + dx; vy = vy - dy; ang = ang + ATAN_TAB[i];
				end else begin
					vx = vx - dx; vy = vy + dy; ang = ang - ATAN_TAB[i];
				end
			end
			if (ang > deg180) ang = ang - 2 * deg180;
			else if (ang <= -deg180) ang = ang + 2 * deg180;
			return ang;
		endfunction

		function void note_point(point_t p);
			s64_t x, y, z, rres, cres, row, col, d, ad, q, elev;
			logic [63:0] hsq, p_range;
			result_t r;
			x = s64_t'(p.point_x);
			y = s64_t'(p.point_y);
			z = s64_t'(p.point_z);
			hsq = x * x + y * y;
			p_range = root_floor(hsq + z * z);
			rres = (regs.row_resolution == 0) ? 1 : s64_t'(regs.row_resolution);
			cres = (regs.column_resolution == 0) ? 1 : s64_t'(regs.column_resolution);
			if (regs.use_ring) begin
				row = s64_t'(p.ring_number);
			end else begin
				elev = vector_angle(z, s64_t'(root_floor(hsq)));
				row = (elev + s64_t'(regs.bottom_angle)) / rres;
			end
			d = vector_angle(x, y) - 90 * 65536;
			ad = (d < 0) ? -d : d;
			q = (2 * ad + cres) / (2 * cres);
			if (d < 0) q = -q;
			col = -q + COLUMNS / 2;
			if (col >= COLUMNS) col = col - COLUMNS;
			r = '0;
			if (row < 0 || row >= ROWS) r.status = ST_ROW;
			else if (col < 0 || col >= COLUMNS) r.status = ST_COL;
			else if (p_range < regs.minimum_range) r.status = ST_CLOSE;
			else r.status = ST_OK;
			if (r.status == ST_OK) begin
				r.image_row = row[3:0];
				r.image_column = col[10:0];
				r.cell_index = 15'(row * COLUMNS + col);
			end
			r.point_range = p_range[23:0];
			pending_cells.insert(pending_cells.size(), r);
		endfunction

		function void check_cell(result_t got);
			result_t exp;
			if (pending_cells.size() == 0) begin
				$error("result with no point pending: %p", got);
				failures++;
				return;
			end
			exp = pending_cells.pop_front();
			if (got.status !== exp.status) begin
				$error("status exp %0d got %0d", exp.status, got.status);
				failures++;
			end
			if (got.image_row !== exp.image_row) begin
				$error("image_row exp %0d got %0d", exp.image_row, got.image_row);
				failures++;
			end
			if (got.image_column !== exp.image_column) begin
				$error("image_column exp %0d got %0d", exp.image_column, got.image_column);
				failures++;
			end
			if (got.cell_index !== exp.cell_index) begin
				$error("cell_index exp %0d got %0d", exp.cell_index, got.cell_index);
				failures++;
			end
			if (got.point_range !== exp.point_range) begin
				$error("point_range exp %0d got %0d", exp.point_range, got.point_range);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_ready;
	point_t point = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cell_board board;
	bit stim_done = 1'b0;

	always #6 clk = ~clk;

	lidar_range_image_projection #(.ROWS(ROWS), .COLUMNS(COLUMNS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_ready(point_ready), .point(point),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// steady stretches with no gaps now and then
	int burst_left = 0;

	// valid stays high into the next item when there is no gap
	task automatic send_point(point_t p, bit gaps);
		int g;
		g = 0;
		if (gaps) begin
			if (burst_left > 0) burst_left--;
			else if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 80);
			else g = gap_len();
		end
		if (g > 0) begin
			point_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		do @(posedge clk); while (!point_ready);
		board.note_point(p);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		point_valid <= 1'b0;
		while (board.pending_cells.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return 24'(int'($urandom_range(0, 8000)) - 4000);
			2: return 24'(int'($urandom_range(0, 200000)) - 100000);
			3: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			4: return 24'(int'($urandom_range(0, 4)) - 2);
			default: return 24'(int'($urandom_range(0, 60000)) - 30000);
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.point_x = rand_coord();
		p.point_y = rand_coord();
		// mostly gentle elevation so rows land inside the image
		if ($urandom_range(0, 3) != 0)
			p.point_z = 24'(int'($urandom_range(0, 6000)) - 3000);
		else
			p.point_z = rand_coord();
		p.ring_number = $urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 17)) : 8'($urandom);
		return p;
	endfunction

	function automatic point_t mk(int x, int y, int z, int ring);
		point_t p;
		p.point_x = 24'(x);
		p.point_y = 24'(y);
		p.point_z = 24'(z);
		p.ring_number = 8'(ring);
		return p;
	endfunction

	// receiver with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) board.check_cell(result);
			if (stim_done && $urandom_range(0, 3) == 0) result_ready <= 1'b1;
			else result_ready <= (gap_len() == 0);
		end
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// axes, origin, extremes, wrap column and near the seam
		send_point(mk(0, 0, 0, 0), 0);
		send_point(mk(5000, 0, 0, 0), 0);
		send_point(mk(-5000, 0, 0, 0), 0);
		send_point(mk(0, 5000, 0, 0), 0);
		send_point(mk(0, -5000, 0, 0), 0);
		send_point(mk(-5000, 1, 0, 0), 0);
		send_point(mk(-5000, -1, 0, 0), 0);
		send_point(mk(3000, 3000, 100, 0), 1);
		send_point(mk(8388607, 8388607, 8388607, 255), 1);
		send_point(mk(-8388608, -8388608, -8388608, 255), 1);
		send_point(mk(4000, 0, 20000, 0), 1);
		send_point(mk(4000, 0, -20000, 0), 1);
		send_point(mk(10, 10, 0, 0), 1);
		send_point(mk(0, 0, 3000, 0), 1);
		send_point(mk(0, 0, -3000, 0), 1);
		drain();
		write_cfg(CFG_USE_RING, CFG_DATA_W'(1));
		send_point(mk(3000, 200, 0, 0), 0);
		send_point(mk(3000, 200, 0, 15), 0);
		send_point(mk(3000, 200, 0, 16), 0);
		send_point(mk(3000, 200, 0, 255), 0);
		drain();

		// settings: use_ring, bottom, row res, col res, min range
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_cfg(CFG_USE_RING, CFG_DATA_W'(0));
					write_cfg(CFG_BOTTOM, CFG_DATA_W'(989594));
					write_cfg(CFG_ROW_RES, CFG_DATA_W'(131072));
					write_cfg(CFG_COL_RES, CFG_DATA_W'(13107));
					write_cfg(CFG_MIN_RANGE, CFG_DATA_W'(1024));
				end
				1: begin
					write_cfg(CFG_BOTTOM, CFG_DATA_W'(0));
					write_cfg(CFG_ROW_RES, CFG_DATA_W'(1));
					write_cfg(CFG_COL_RES, CFG_DATA_W'(1));
					write_cfg(CFG_MIN_RANGE, CFG_DATA_W'(0));
				end
				2: begin
					write_cfg(CFG_BOTTOM, CFG_DATA_W'(5898240));
					write_cfg(CFG_ROW_RES, CFG_DATA_W'(655360));
					write_cfg(CFG_COL_RES, CFG_DATA_W'(655360));
					write_cfg(CFG_MIN_RANGE, CFG_DATA_W'(1048576));
				end
				3: begin
					write_cfg(CFG_ROW_RES, CFG_DATA_W'(0));
					write_cfg(CFG_COL_RES, CFG_DATA_W'(0));
					write_cfg(CFG_BOTTOM, 23'h7fffff);
					write_cfg(CFG_MIN_RANGE, CFG_DATA_W'(21'h1fffff));
				end
				4: begin
					write_cfg(CFG_USE_RING, CFG_DATA_W'(1));
					write_cfg(CFG_COL_RES, CFG_DATA_W'(2000));
					write_cfg(CFG_MIN_RANGE, CFG_DATA_W'(500));
				end
				5: begin
					write_cfg(CFG_USE_RING, CFG_DATA_W'(0));
					write_cfg(CFG_BOTTOM, CFG_DATA_W'(989594));
					write_cfg(CFG_ROW_RES, CFG_DATA_W'(131072));
					write_cfg(CFG_COL_RES, CFG_DATA_W'(13107));
					write_cfg(CFG_MIN_RANGE, CFG_DATA_W'(1024));
				end
				default: begin
					write_cfg(CFG_USE_RING, CFG_DATA_W'($urandom_range(0, 1)));
					write_cfg(CFG_BOTTOM, CFG_DATA_W'($urandom_range(0, 5898240)));
					write_cfg(CFG_ROW_RES, CFG_DATA_W'($urandom_range(1, 655360)));
					write_cfg(CFG_COL_RES, CFG_DATA_W'($urandom_range(1, 655360)));
					write_cfg(CFG_MIN_RANGE, CFG_DATA_W'($urandom_range(0, 1048576)));
				end
			endcase
			for (int n = 0; n < 190; n++) send_point(rand_point(), 1);
			drain();
		end

		stim_done = 1'b1;
		drain();
		if (board.failures == 0 && board.pending_cells.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
